// ===== hdl/playlist_list_with_cursor_top_macros.svh =====
`ifndef PLAYLIST_LIST_WITH_CURSOR_TOP_MACROS_SVH
`define PLAYLIST_LIST_WITH_CURSOR_TOP_MACROS_SVH

// same-cycle implication under reset
`define PLWC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("playlist list check failed");

// next-cycle implication under reset
`define PLWC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("playlist list check failed");

`endif

// ===== hdl/plwc_pkg.sv =====
package plwc_pkg;

    typedef enum logic [2:0] {
        OP_APPEND  = 3'd0,
        OP_NEXT    = 3'd1,
        OP_PREV    = 3'd2,
        OP_REM_HD  = 3'd3,
        OP_INSERT  = 3'd4,
        OP_DELETE  = 3'd5,
        OP_RESTART = 3'd6,
        OP_CLEAR   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_EMPTY   = 3'd1,
        STAT_NO_NEXT = 3'd2,
        STAT_NO_PREV = 3'd3,
        STAT_RANGE   = 3'd4,
        STAT_FULL    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_WRITE_ID,
        S_READ_CUR,
        S_RESULT
    } state_t;

    localparam int ID_FIELD_W  = 16;
    localparam int POS_FIELD_W = 7;
    localparam int CUR_FIELD_W = 6;
    localparam int CNT_FIELD_W = 7;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 32;

endpackage

// ===== hdl/plwc_ram.sv =====
module plwc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rd_data_reg
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

endmodule

// ===== hdl/playlist_list_with_cursor_top.sv =====
// channel   direction  handshake            payload
// s_        in         s_tvalid / s_tready  command request (op, id, position)
// m_        out        m_tvalid / m_tready  result request (status, cursor, id, count)
// cfg_      in         cfg_valid/cfg_ready  loop_mode, always ready
//
// a plain command passes S_DECODE, S_READ_CUR and S_RESULT after accept, then returns to S_IDLE
// remove head and delete add S_SHIFT, insert adds S_SHIFT and S_WRITE_ID (up to CAPACITY-1 entries moved)
// entries move one per cycle through the single read and write port of the store
// s_tready is high only while idle; a finished result waits in the output register
// synchronous active-low reset clears list count, cursor, mode and handshakes
`include "playlist_list_with_cursor_top_macros.svh"

module playlist_list_with_cursor_top #(
    parameter int CAPACITY = 64,
    parameter int ID_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] operation, [18:3] song_id, [25:19] position, [31:26] zero
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [8:3] cursor_position, [24:9] current_song, [31:25] entry_count
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data
);

    localparam int STORE_W = (ID_WIDTH < plwc_pkg::ID_FIELD_W) ? ID_WIDTH
                                                               : plwc_pkg::ID_FIELD_W;
    localparam int AW      = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CW      = (CNT_W > plwc_pkg::POS_FIELD_W) ? CNT_W
                                                             : plwc_pkg::POS_FIELD_W;

    plwc_pkg::state_t  state_reg, state_next;
    plwc_pkg::status_t status_reg, status_next;
    plwc_pkg::op_t     op_reg;
    logic [STORE_W-1:0]                id_reg;
    logic [plwc_pkg::POS_FIELD_W-1:0]  pos_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]    cursor_reg, cursor_next;
    logic [AW-1:0]    rd_idx_reg, rd_idx_next;
    logic [AW-1:0]    wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             pend_reg, pend_next;
    logic             up_reg, up_next;
    logic             loop_reg;
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_data_reg;
    logic             load_out;

    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [STORE_W-1:0] ram_wdata, ram_rdata;

    logic [CW-1:0] cnt_x, pos_x, cur_x, dcnt_x, dcur_x, tmp_x;

    assign s_tready  = (state_reg == plwc_pkg::S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign cfg_ready = 1'b1;

    assign cnt_x = CW'(count_reg);
    assign pos_x = CW'(pos_reg);
    assign cur_x = CW'(cursor_reg);

    plwc_ram #(
        .WIDTH(STORE_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .aclk       (aclk),
        .we         (ram_we),
        .waddr      (ram_waddr),
        .wdata      (ram_wdata),
        .re         (ram_re),
        .raddr      (ram_raddr),
        .rd_data_reg(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= plwc_pkg::S_IDLE;
            status_reg  <= plwc_pkg::STAT_OK;
            count_reg   <= '0;
            cursor_reg  <= '0;
            rd_idx_reg  <= '0;
            wr_idx_reg  <= '0;
            left_reg    <= '0;
            pend_reg    <= 1'b0;
            up_reg      <= 1'b0;
            loop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            rd_idx_reg  <= rd_idx_next;
            wr_idx_reg  <= wr_idx_next;
            left_reg    <= left_next;
            pend_reg    <= pend_next;
            up_reg      <= up_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                loop_reg <= cfg_data[0];
            end
        end
    end

    // command and result payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg  <= plwc_pkg::op_t'(s_tdata[2:0]);
            id_reg  <= s_tdata[3 +: STORE_W];
            pos_reg <= s_tdata[19 +: plwc_pkg::POS_FIELD_W];
        end
        if (load_out) begin
            m_data_reg[2:0]   <= status_reg;
            m_data_reg[8:3]   <= cur_x[plwc_pkg::CUR_FIELD_W-1:0];
            m_data_reg[24:9]  <= (count_reg == '0) ? '0 : plwc_pkg::ID_FIELD_W'(ram_rdata);
            m_data_reg[31:25] <= cnt_x[plwc_pkg::CNT_FIELD_W-1:0];
        end
    end

    always_comb begin
        state_next   = state_reg;
        status_next  = status_reg;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        rd_idx_next  = rd_idx_reg;
        wr_idx_next  = wr_idx_reg;
        left_next    = left_reg;
        pend_next    = pend_reg;
        up_next      = up_reg;
        m_valid_next = m_valid_reg;
        load_out     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = wr_idx_reg;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = rd_idx_reg;
        dcnt_x       = cnt_x - CW'(1);
        dcur_x       = (pos_x < cur_x) ? (cur_x - CW'(1)) : cur_x;
        tmp_x        = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            plwc_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = plwc_pkg::S_DECODE;
                end
            end
            plwc_pkg::S_DECODE: begin
                status_next = plwc_pkg::STAT_OK;
                state_next  = plwc_pkg::S_READ_CUR;
                pend_next   = 1'b0;
                case (op_reg)
                    plwc_pkg::OP_APPEND: begin
                        if (cnt_x == CW'(CAPACITY)) begin
                            status_next = plwc_pkg::STAT_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = cnt_x[AW-1:0];
                            ram_wdata  = id_reg;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    plwc_pkg::OP_NEXT: begin
                        if (count_reg == '0) begin
                            status_next = plwc_pkg::STAT_EMPTY;
                        end else if (cur_x + CW'(1) < cnt_x) begin
                            cursor_next = cursor_reg + AW'(1);
                        end else if (loop_reg) begin
                            cursor_next = '0;
                        end else begin
                            status_next = plwc_pkg::STAT_NO_NEXT;
                        end
                    end
                    plwc_pkg::OP_PREV: begin
                        if (count_reg == '0) begin
                            status_next = plwc_pkg::STAT_EMPTY;
                        end else if (cursor_reg != '0) begin
                            cursor_next = cursor_reg - AW'(1);
                        end else if (loop_reg) begin
                            cursor_next = dcnt_x[AW-1:0];
                        end else begin
                            status_next = plwc_pkg::STAT_NO_PREV;
                        end
                    end
                    plwc_pkg::OP_REM_HD: begin
                        if (count_reg == '0) begin
                            status_next = plwc_pkg::STAT_EMPTY;
                        end else begin
                            left_next   = dcnt_x[CNT_W-1:0];
                            rd_idx_next = AW'(1);
                            up_next     = 1'b0;
                            count_next  = dcnt_x[CNT_W-1:0];
                            if (cursor_reg != '0) begin
                                cursor_next = cursor_reg - AW'(1);
                            end
                            state_next = plwc_pkg::S_SHIFT;
                        end
                    end
                    plwc_pkg::OP_INSERT: begin
                        if (count_reg == '0 && pos_reg != '0) begin
                            status_next = plwc_pkg::STAT_EMPTY;
                        end else if (pos_x > cnt_x) begin
                            status_next = plwc_pkg::STAT_RANGE;
                        end else if (cnt_x == CW'(CAPACITY)) begin
                            status_next = plwc_pkg::STAT_FULL;
                        end else begin
                            tmp_x       = cnt_x - pos_x;
                            left_next   = tmp_x[CNT_W-1:0];
                            rd_idx_next = dcnt_x[AW-1:0];
                            up_next     = 1'b1;
                            count_next  = count_reg + CNT_W'(1);
                            if (count_reg != '0 && pos_x <= cur_x) begin
                                cursor_next = cursor_reg + AW'(1);
                            end
                            state_next = plwc_pkg::S_SHIFT;
                        end
                    end
                    plwc_pkg::OP_DELETE: begin
                        if (count_reg == '0 && pos_reg != '0) begin
                            status_next = plwc_pkg::STAT_EMPTY;
                        end else if (pos_x >= cnt_x) begin
                            status_next = plwc_pkg::STAT_RANGE;
                        end else begin
                            tmp_x       = dcnt_x - pos_x;
                            left_next   = tmp_x[CNT_W-1:0];
                            tmp_x       = pos_x + CW'(1);
                            rd_idx_next = tmp_x[AW-1:0];
                            up_next     = 1'b0;
                            count_next  = dcnt_x[CNT_W-1:0];
                            if (dcnt_x == '0) begin
                                cursor_next = '0;
                            end else if (dcur_x >= dcnt_x) begin
                                tmp_x       = dcnt_x - CW'(1);
                                cursor_next = tmp_x[AW-1:0];
                            end else begin
                                cursor_next = dcur_x[AW-1:0];
                            end
                            state_next = plwc_pkg::S_SHIFT;
                        end
                    end
                    plwc_pkg::OP_RESTART: begin
                        if (count_reg == '0) begin
                            status_next = plwc_pkg::STAT_EMPTY;
                        end else begin
                            cursor_next = '0;
                        end
                    end
                    default: begin
                        count_next  = '0;
                        cursor_next = '0;
                    end
                endcase
            end
            plwc_pkg::S_SHIFT: begin
                // each cycle: one read issued while entries remain, one earlier pending read written back
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_idx_reg;
                    ram_wdata = ram_rdata;
                end
                if (left_reg != '0) begin
                    ram_re      = 1'b1;
                    ram_raddr   = rd_idx_reg;
                    pend_next   = 1'b1;
                    wr_idx_next = up_reg ? (rd_idx_reg + AW'(1)) : (rd_idx_reg - AW'(1));
                    rd_idx_next = up_reg ? (rd_idx_reg - AW'(1)) : (rd_idx_reg + AW'(1));
                    left_next   = left_reg - CNT_W'(1);
                end else begin
                    pend_next  = 1'b0;
                    state_next = up_reg ? plwc_pkg::S_WRITE_ID : plwc_pkg::S_READ_CUR;
                end
            end
            plwc_pkg::S_WRITE_ID: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_x[AW-1:0];
                ram_wdata  = id_reg;
                state_next = plwc_pkg::S_READ_CUR;
            end
            plwc_pkg::S_READ_CUR: begin
                ram_re     = 1'b1;
                ram_raddr  = cursor_reg;
                state_next = plwc_pkg::S_RESULT;
            end
            plwc_pkg::S_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = plwc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = plwc_pkg::S_IDLE;
            end
        endcase
    end

    `PLWC_ASSERT_NOW(a_count_cap, aclk, aresetn, 1'b1, cnt_x <= CW'(CAPACITY))
    `PLWC_ASSERT_NOW(a_cursor_in_list, aclk, aresetn, 1'b1, (count_reg == '0) ? (cursor_reg == '0) : (cur_x < cnt_x))
    `PLWC_ASSERT_NEXT(a_accept_decode, aclk, aresetn, s_tvalid && s_tready, state_reg == plwc_pkg::S_DECODE)
    `PLWC_ASSERT_NEXT(a_shift_ends, aclk, aresetn, state_reg == plwc_pkg::S_SHIFT && left_reg == '0, state_reg != plwc_pkg::S_SHIFT && !pend_reg)

endmodule
